// ===== design/mrg_pkg.sv =====
`default_nettype none

package mrg_pkg;

   // Width of the column count register.
   localparam int COL_BITS = 7;

   typedef enum logic [2:0] {
      ROW_HOLD,
      ROW_START,
      ROW_HSTEP,
      ROW_VSTEP,
      ROW_RESTART
   } row_op_type;

   typedef struct packed {
      row_op_type op;
      logic       use_col;
      logic       choice;
   } row_cmd_type;

   typedef struct packed {
      logic wall;
      logic floor;
   } row_stat_type;

endpackage

`default_nettype wire

// ===== design/maze_row_generator.sv =====
`default_nettype none

// Channel  Direction  Handshake                Contents
// req      in         req_tvalid / req_tready  tuser: req_type; tdata: wall and floor choices
// rsp      out        rsp_tvalid / rsp_tready  tdata: right_walls, bottom_walls
// csr      in         csr_we                   csr_wdata: active_columns
//
// An ordinary row runs a join pass over all columns, then a floor pass, and
// then presents its result; a final row runs the join pass, then a restart of
// the labels, and then presents its result. The label row rotates one column
// per cycle past position zero, first to join sets, then, in an ordinary row,
// to place floors. The block takes no new transaction while a row is in work. A
// result held by a stalled rsp side blocks the next row only at its end. Reset
// is synchronous and restores the column labels and the label counter.

module maze_row_generator import mrg_pkg::*; #(
   parameter int MAX_COLUMNS = 64,
   parameter int LABEL_BITS  = 16,
   localparam int DATA_BITS  = ((2 * MAX_COLUMNS - 1 + 7) / 8) * 8
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output      logic                    req_tready,
   // [MAX_COLUMNS-2:0] wall_choices, [2*MAX_COLUMNS-2:MAX_COLUMNS-1] floor_choices
   input  wire logic [DATA_BITS-1:0]    req_tdata,
   // [0] req_type
   input  wire logic                    req_tuser,
   output      logic                    rsp_tvalid,
   input  wire logic                    rsp_tready,
   // [MAX_COLUMNS-2:0] right_walls, [2*MAX_COLUMNS-2:MAX_COLUMNS-1] bottom_walls
   output      logic [DATA_BITS-1:0]    rsp_tdata,
   input  wire logic                    csr_we,
   input  wire logic [COL_BITS-1:0]     csr_wdata
);

   localparam int STEP_BITS = $clog2(MAX_COLUMNS);
   localparam int RESET_COLS = (MAX_COLUMNS < 64) ? MAX_COLUMNS : 64;

   typedef enum logic [2:0] {
      S_IDLE,
      S_HPASS,
      S_VPASS,
      S_RESTART,
      S_OUT
   } state_type;

   state_type              state_ff;
   logic [STEP_BITS-1:0]   step_ff;
   logic [COL_BITS-1:0]    cols_cfg_ff;
   logic [COL_BITS-1:0]    cols;
   logic                   final_ff;
   logic                   rsp_final_ff;
   logic [MAX_COLUMNS-2:0] wall_sh_ff;
   logic [MAX_COLUMNS-1:0] floor_sh_ff;
   logic [MAX_COLUMNS-1:0] right_sh_ff;
   logic                   rsp_valid_ff;
   logic [DATA_BITS-1:0]   rsp_data_ff;
   logic                   last_step;
   logic                   req_accept;
   row_cmd_type            row_cmd;
   row_stat_type           row_stat;
   logic [MAX_COLUMNS-1:0] row_bottom;

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign last_step  = (step_ff == STEP_BITS'(MAX_COLUMNS - 1));

   always_comb begin
      if (cols_cfg_ff < COL_BITS'(2)) begin
         cols = COL_BITS'(2);
      end else if (cols_cfg_ff > COL_BITS'(MAX_COLUMNS)) begin
         cols = COL_BITS'(MAX_COLUMNS);
      end else begin
         cols = cols_cfg_ff;
      end
   end

   always_comb begin
      row_cmd = '{op: ROW_HOLD, use_col: 1'b0, choice: 1'b0};
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               row_cmd.op = ROW_START;
            end
         end
         S_HPASS: begin
            row_cmd.op      = ROW_HSTEP;
            row_cmd.use_col = (COL_BITS'(step_ff) + COL_BITS'(1)) < cols;
            row_cmd.choice  = wall_sh_ff[0] && !final_ff;
         end
         S_VPASS: begin
            row_cmd.op      = ROW_VSTEP;
            row_cmd.use_col = COL_BITS'(step_ff) < cols;
            row_cmd.choice  = floor_sh_ff[0];
         end
         S_RESTART: begin
            row_cmd.op = ROW_RESTART;
         end
         S_OUT: begin
         end
         default: begin
         end
      endcase
   end

   mrg_row #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .LABEL_BITS  (LABEL_BITS)
   ) u_row (
      .clock  (clock),
      .reset  (reset),
      .cmd    (row_cmd),
      .cols   (cols),
      .stat   (row_stat),
      .bottom (row_bottom)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_cfg_ff <= COL_BITS'(RESET_COLS);
      end else if (csr_we) begin
         cols_cfg_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready && (state_ff != S_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_accept) begin
                  final_ff    <= req_tuser;
                  wall_sh_ff  <= req_tdata[MAX_COLUMNS-2:0];
                  floor_sh_ff <= req_tdata[2*MAX_COLUMNS-2:MAX_COLUMNS-1];
                  step_ff     <= '0;
                  state_ff    <= S_HPASS;
               end
            end
            S_HPASS: begin
               right_sh_ff <= {row_stat.wall, right_sh_ff[MAX_COLUMNS-1:1]};
               wall_sh_ff  <= wall_sh_ff >> 1;
               if (last_step) begin
                  step_ff  <= '0;
                  state_ff <= final_ff ? S_RESTART : S_VPASS;
               end else begin
                  step_ff <= step_ff + STEP_BITS'(1);
               end
            end
            S_VPASS: begin
               floor_sh_ff <= floor_sh_ff >> 1;
               if (last_step) begin
                  step_ff  <= '0;
                  state_ff <= S_OUT;
               end else begin
                  step_ff <= step_ff + STEP_BITS'(1);
               end
            end
            S_RESTART: begin
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_data_ff  <= DATA_BITS'({row_bottom, right_sh_ff[MAX_COLUMNS-2:0]});
                  rsp_final_ff <= final_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // A new transaction always starts the join pass at the first column.
   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == S_HPASS) && (step_ff == '0))
      else $error("row did not start at the first column");

   // A final row never carries a bottom wall.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_final_ff) |-> (rsp_data_ff[2*MAX_COLUMNS-2:MAX_COLUMNS-1] == '0))
      else $error("bottom wall on a final row");

   // A result only appears at the end of a row's work.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_OUT))
      else $error("result raised outside the output state");

endmodule

`default_nettype wire

// ===== design/mrg_row.sv =====
`default_nettype none

module mrg_row import mrg_pkg::*; #(
   parameter int MAX_COLUMNS = 64,
   parameter int LABEL_BITS  = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire row_cmd_type            cmd,
   input  wire logic [COL_BITS-1:0]    cols,
   output      row_stat_type           stat,
   output      logic [MAX_COLUMNS-1:0] bottom
);

   localparam int RESET_COLS = (MAX_COLUMNS < 64) ? MAX_COLUMNS : 64;

   logic [LABEL_BITS-1:0]  lab_ff  [MAX_COLUMNS];
   logic [LABEL_BITS-1:0]  lab_in  [MAX_COLUMNS];
   logic [LABEL_BITS-1:0]  tmp_lab [MAX_COLUMNS];
   logic [MAX_COLUMNS-1:0] act_ff, act_in;
   logic [MAX_COLUMNS-1:0] bot_ff, bot_in;
   logic [MAX_COLUMNS-1:0] tmp_bot;
   logic [MAX_COLUMNS-1:0] eq;
   logic [LABEL_BITS-1:0]  counter_ff, counter_in;
   logic [LABEL_BITS-1:0]  lab_a, lab_b;
   logic                   wall, join_sets, many, floor_set;

   assign lab_a  = lab_ff[0];
   assign lab_b  = lab_ff[1];
   assign bottom = bot_ff;

   // The label row rotates by one position on every pass step, so the column
   // under work always sits at position zero and a full pass realigns it.
   always_comb begin
      lab_in     = lab_ff;
      act_in     = act_ff;
      bot_in     = bot_ff;
      counter_in = counter_ff;
      tmp_lab    = lab_ff;
      tmp_bot    = bot_ff;
      stat       = '0;
      wall       = 1'b0;
      join_sets  = 1'b0;
      many       = 1'b0;
      floor_set  = 1'b0;
      for (int p = 0; p < MAX_COLUMNS; p++) begin
         eq[p] = act_ff[p] && !bot_ff[p] && (lab_ff[p] == lab_a);
      end
      unique case (cmd.op)
         ROW_HOLD: begin
         end
         ROW_START: begin
            for (int p = 0; p < MAX_COLUMNS; p++) begin
               act_in[p] = (COL_BITS'(p) < cols);
            end
            bot_in = '0;
         end
         ROW_HSTEP: begin
            wall      = (lab_a == lab_b) || cmd.choice;
            join_sets = cmd.use_col && !wall;
            stat.wall = cmd.use_col && wall;
            for (int p = 0; p < MAX_COLUMNS; p++) begin
               if (join_sets && act_ff[p] && (lab_ff[p] == lab_b)) begin
                  tmp_lab[p] = lab_a;
               end
            end
            for (int p = 0; p < MAX_COLUMNS; p++) begin
               lab_in[p] = tmp_lab[(p + 1) % MAX_COLUMNS];
               act_in[p] = act_ff[(p + 1) % MAX_COLUMNS];
               bot_in[p] = bot_ff[(p + 1) % MAX_COLUMNS];
            end
         end
         ROW_VSTEP: begin
            // At least two open cells share this set when clearing the lowest
            // set bit of the match vector still leaves a bit.
            many       = |(eq & (eq - MAX_COLUMNS'(1)));
            floor_set  = cmd.use_col && many && cmd.choice;
            stat.floor = floor_set;
            if (floor_set) begin
               tmp_lab[0] = counter_ff;
               tmp_bot[0] = 1'b1;
               counter_in = counter_ff + LABEL_BITS'(1);
            end
            for (int p = 0; p < MAX_COLUMNS; p++) begin
               lab_in[p] = tmp_lab[(p + 1) % MAX_COLUMNS];
               act_in[p] = act_ff[(p + 1) % MAX_COLUMNS];
               bot_in[p] = tmp_bot[(p + 1) % MAX_COLUMNS];
            end
         end
         ROW_RESTART: begin
            for (int p = 0; p < MAX_COLUMNS; p++) begin
               lab_in[p] = LABEL_BITS'(p + 1);
            end
            counter_in = LABEL_BITS'(cols) + LABEL_BITS'(1);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < MAX_COLUMNS; p++) begin
            lab_ff[p] <= LABEL_BITS'(p + 1);
         end
         act_ff     <= '0;
         bot_ff     <= '0;
         counter_ff <= LABEL_BITS'(RESET_COLS + 1);
      end else begin
         lab_ff     <= lab_in;
         act_ff     <= act_in;
         bot_ff     <= bot_in;
         counter_ff <= counter_in;
      end
   end

endmodule

`default_nettype wire
